// ----- src/bcn_pkg.sv -----
package bcn_pkg;

    // block format codes
    localparam logic [2:0] FMT_BC1 = 3'd0;
    localparam logic [2:0] FMT_BC2 = 3'd1;
    localparam logic [2:0] FMT_BC3 = 3'd2;
    localparam logic [2:0] FMT_BC4 = 3'd3;
    localparam logic [2:0] FMT_BC5 = 3'd4;

    localparam int unsigned PIXELS = 16;
    localparam int unsigned PIX_W  = 4;

    typedef struct packed {
        logic              valid;
        logic [2:0]        fmt;
        logic [PIX_W-1:0]  pix;
        logic [63:0]       lo;
        logic [63:0]       hi;
    } t_pix_req;

    typedef struct packed {
        logic              valid;
        logic [PIX_W-1:0]  index;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic              last;
    } t_pixel;

    // 5-bit field to 8 bits with rounding
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [12:0] t;
        logic [12:0] s;
        begin
            t = 13'(v) * 13'd255 + 13'd16;
            s = (t >> 5) + t;
            return s[12:5];
        end
    endfunction

    // 6-bit field to 8 bits with rounding
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [13:0] t;
        logic [13:0] s;
        begin
            t = 14'(v) * 14'd255 + 14'd32;
            s = (t >> 6) + t;
            return s[13:6];
        end
    endfunction

    // reciprocal multiplies, exact for the ranges used here
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] m;
        begin
            m = 21'(x) * 21'd683;
            return m[18:11];
        end
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] m;
        begin
            m = 24'(x) * 24'd1639;
            return m[20:13];
        end
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] m;
        begin
            m = 25'(x) * 25'd2341;
            return m[21:14];
        end
    endfunction

endpackage

// ----- src/bcn_pixel_pipe.sv -----
module bcn_pixel_pipe
    import bcn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_pix_req i_req,
    output t_pixel   o_pix
);

    typedef enum logic [2:0] {
        SEL_E0,
        SEL_E1,
        SEL_DIV7,
        SEL_DIV5,
        SEL_ZERO,
        SEL_FULL
    } t_chsel;

    typedef struct packed {
        t_chsel      sel;
        logic [7:0]  e0;
        logic [7:0]  e1;
        logic [10:0] num;
    } t_chan;

    typedef struct packed {
        logic [1:0]      idx;
        logic            four;
        logic [2:0][7:0] c0;
        logic [2:0][7:0] c1;
    } t_colour;

    function automatic t_chan chan_prep(input logic [63:0] bits, input logic [PIX_W-1:0] p);
        t_chan      c;
        logic [5:0] pos;
        logic [2:0] k;
        logic [2:0] w0;
        logic [2:0] w1;
        logic       gt;
        begin
            pos  = 6'd16 + 6'(p) * 6'd3;
            k    = bits[pos +: 3];
            c.e0 = bits[7:0];
            c.e1 = bits[15:8];
            gt   = c.e0 > c.e1;
            w1   = k - 3'd1;
            w0   = gt ? 3'(4'd8 - 4'(k)) : 3'(4'd6 - 4'(k));
            c.num = 11'(w0) * 11'(c.e0) + 11'(w1) * 11'(c.e1);
            if (k == 3'd0) begin
                c.sel = SEL_E0;
            end else if (k == 3'd1) begin
                c.sel = SEL_E1;
            end else if (gt) begin
                c.sel = SEL_DIV7;
            end else if (k == 3'd6) begin
                c.sel = SEL_ZERO;
            end else if (k == 3'd7) begin
                c.sel = SEL_FULL;
            end else begin
                c.sel = SEL_DIV5;
            end
            return c;
        end
    endfunction

    function automatic logic [7:0] chan_value(input t_chan c);
        logic [7:0] v;
        begin
            case (c.sel)
                SEL_E0:   v = c.e0;
                SEL_E1:   v = c.e1;
                SEL_DIV7: v = div7(c.num);
                SEL_DIV5: v = div5(c.num);
                SEL_ZERO: v = 8'd0;
                SEL_FULL: v = 8'd255;
                default:  v = 8'd0;
            endcase
            return v;
        end
    endfunction

    function automatic t_colour colour_prep(input logic [63:0] bits, input logic [PIX_W-1:0] p,
                                            input logic force_four);
        t_colour    c;
        logic [5:0] pos;
        logic [15:0] w0;
        logic [15:0] w1;
        begin
            w0     = bits[15:0];
            w1     = bits[31:16];
            pos    = 6'd32 + 6'(p) * 6'd2;
            c.idx  = bits[pos +: 2];
            c.four = force_four || (w0 > w1);
            c.c0[0] = widen5(w0[15:11]);
            c.c0[1] = widen6(w0[10:5]);
            c.c0[2] = widen5(w0[4:0]);
            c.c1[0] = widen5(w1[15:11]);
            c.c1[1] = widen6(w1[10:5]);
            c.c1[2] = widen5(w1[4:0]);
            return c;
        end
    endfunction

    // stage 1: index extraction, endpoint widening, interpolation numerators
    logic             r1_valid;
    logic [2:0]       r1_fmt;
    logic [PIX_W-1:0] r1_index;
    logic [7:0]       r1_alpha4;
    t_colour          r1_col;
    t_chan            r1_cha;
    t_chan            r1_chb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_fmt    <= i_req.fmt;
            r1_index  <= i_req.pix;
            r1_alpha4 <= {2{i_req.lo[{i_req.pix, 2'b00} +: 4]}};
            r1_col    <= colour_prep((i_req.fmt == FMT_BC1) ? i_req.lo : i_req.hi, i_req.pix,
                                     i_req.fmt != FMT_BC1);
            r1_cha    <= chan_prep(i_req.lo, i_req.pix);
            r1_chb    <= chan_prep(i_req.hi, i_req.pix);
        end
    end

    // stage 2: divisions and final channel selection
    logic [2:0][7:0] n_rgb;
    logic [7:0]      n_col_alpha;
    logic [7:0]      n_cha;
    logic [7:0]      n_chb;
    t_pixel          n_pix;
    t_pixel          r_pix;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r1_col.idx)
                2'd0: n_rgb[c] = r1_col.c0[c];
                2'd1: n_rgb[c] = r1_col.c1[c];
                2'd2: n_rgb[c] = r1_col.four
                          ? div3({1'b0, r1_col.c0[c], 1'b0} + 10'(r1_col.c1[c]))
                          : 8'((9'(r1_col.c0[c]) + 9'(r1_col.c1[c])) >> 1);
                default: n_rgb[c] = r1_col.four
                          ? div3(10'(r1_col.c0[c]) + {1'b0, r1_col.c1[c], 1'b0})
                          : 8'd0;
            endcase
        end
        n_col_alpha = (r1_col.idx == 2'd3 && !r1_col.four) ? 8'd0 : 8'd255;
        n_cha = chan_value(r1_cha);
        n_chb = chan_value(r1_chb);

        n_pix.valid = r1_valid;
        n_pix.index = r1_index;
        n_pix.last  = (r1_index == PIX_W'(PIXELS - 1));
        case (r1_fmt)
            FMT_BC1: begin
                n_pix.red   = n_rgb[0];
                n_pix.green = n_rgb[1];
                n_pix.blue  = n_rgb[2];
                n_pix.alpha = n_col_alpha;
            end
            FMT_BC2: begin
                n_pix.red   = n_rgb[0];
                n_pix.green = n_rgb[1];
                n_pix.blue  = n_rgb[2];
                n_pix.alpha = r1_alpha4;
            end
            FMT_BC3: begin
                n_pix.red   = n_rgb[0];
                n_pix.green = n_rgb[1];
                n_pix.blue  = n_rgb[2];
                n_pix.alpha = n_cha;
            end
            FMT_BC4: begin
                n_pix.red   = n_cha;
                n_pix.green = n_cha;
                n_pix.blue  = n_cha;
                n_pix.alpha = 8'd255;
            end
            FMT_BC5: begin
                n_pix.red   = n_cha;
                n_pix.green = n_chb;
                n_pix.blue  = 8'd0;
                n_pix.alpha = 8'd255;
            end
            default: begin
                n_pix.red   = 8'd0;
                n_pix.green = 8'd0;
                n_pix.blue  = 8'd0;
                n_pix.alpha = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix.valid <= 1'b0;
        end else if (i_en) begin
            r_pix.valid <= n_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix.index <= n_pix.index;
            r_pix.red   <= n_pix.red;
            r_pix.green <= n_pix.green;
            r_pix.blue  <= n_pix.blue;
            r_pix.alpha <= n_pix.alpha;
            r_pix.last  <= n_pix.last;
        end
    end

    assign o_pix = r_pix;

endmodule

// ----- src/bcn_block_decoder.sv -----
// 4x4 block texture decoder for BC1, BC2, BC3, BC4 and BC5.
// input channel: i_valid / o_stall carries one 16-byte block per request,
//   bytes 0..7 on i_block_low and 8..15 on i_block_high, byte 0 in the low bits
// output channel: o_valid / i_stall carries one RGBA8 pixel per request in
//   raster order, o_texel_pos = row * 4 + column, o_last_pixel on pixel 15
// block_format is written through the APB port at address 0; write it only while idle
//   (not enforced by the block); the value is sampled when a block is taken
// the first pixel of a block passes the block register, the decode register and the
//   output register, then one pixel per cycle while i_stall does not hold the output
// a pixel counter walks the held block one pixel a cycle while the pipe advances; the
//   next block is taken in the cycle pixel 15 leaves the block register, so blocks
//   follow with no gap
// the three stages (block register, decode register, output register) share one
//   advance enable: while i_stall holds the output, the whole pipe freezes
// reset clears the format to BC1 and empties the pipe; no clearing pass is needed
module bcn_block_decoder
    import bcn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_texel_pos,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_pixel,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_BLOCK_FORMAT = 1'b0;

    logic             r_busy;
    logic [PIX_W-1:0] r_pix;
    logic [2:0]       r_fmt;
    logic [63:0]      r_lo;
    logic [63:0]      r_hi;
    logic [2:0]       r_block_format;

    logic     adv;
    logic     accept;
    logic     cfg_wr;
    t_pix_req req;
    t_pixel   pix;

    assign adv     = !pix.valid || !i_stall;
    assign o_stall = r_busy && !(adv && r_pix == PIX_W'(PIXELS - 1));
    assign accept  = i_valid && !o_stall;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_FORMAT);
    assign prdata = (paddr[2] == REG_BLOCK_FORMAT) ? {29'd0, r_block_format} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_pix          <= '0;
            r_block_format <= FMT_BC1;
        end else begin
            if (cfg_wr) begin
                r_block_format <= pwdata[2:0];
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_pix  <= '0;
            end else if (r_busy && adv) begin
                r_pix <= r_pix + 1'b1;
                if (r_pix == PIX_W'(PIXELS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo  <= i_block_low;
            r_hi  <= i_block_high;
            r_fmt <= r_block_format;
        end
    end

    assign req.valid = r_busy;
    assign req.fmt   = r_fmt;
    assign req.pix   = r_pix;
    assign req.lo    = r_lo;
    assign req.hi    = r_hi;

    bcn_pixel_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_req   (req),
        .o_pix   (pix)
    );

    assign o_valid       = pix.valid;
    assign o_texel_pos   = pix.index;
    assign o_red         = pix.red;
    assign o_green       = pix.green;
    assign o_blue        = pix.blue;
    assign o_alpha       = pix.alpha;
    assign o_last_pixel  = pix.last;

`ifndef SYNTHESIS
    // a taken block starts at pixel 0
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy && r_pix == '0)
        else $error("block request did not restart pixel walk");

    // no new block while the current one is mid-walk
    a_stall_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_pix != PIX_W'(PIXELS - 1) |-> o_stall)
        else $error("input not stalled while block in progress");

    // walk keeps going until pixel 15 has left
    a_walk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && adv && r_pix != PIX_W'(PIXELS - 1) |=> r_busy && r_pix == $past(r_pix) + 1'b1)
        else $error("pixel walk lost a step");

    // last marker only on pixel 15
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_pixel == (o_texel_pos == PIX_W'(PIXELS - 1))))
        else $error("last pixel marker mismatch");
`endif

endmodule

// ----- dv/bcn_block_checker.sv -----
module bcn_block_checker
    import bcn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_texel_pos,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic        i_last_pixel,

    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,

    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef struct packed {
        logic [3:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_texel;

    t_texel      texel_q[$];
    logic [2:0]  cur_format;
    int          fails;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        int unsigned t;
        t = v * 255 + 16;
        return 8'(((t >> 5) + t) >> 5);
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        int unsigned t;
        t = v * 255 + 32;
        return 8'(((t >> 6) + t) >> 6);
    endfunction

    // c0 in bits 15:0, c1 in 31:16, 2-bit selectors from bit 32
    function automatic t_rgba colour_texel(input logic [63:0] bits, input int p,
                                           input bit force_four);
        logic [15:0] w0;
        logic [15:0] w1;
        logic [1:0]  sel;
        bit          four;
        int unsigned e0[3];
        int unsigned e1[3];
        int unsigned v[3];
        t_rgba       px;
        w0 = bits[15:0];
        w1 = bits[31:16];
        sel = bits[32 + 2*p +: 2];
        four = force_four || (w0 > w1);
        e0[0] = 32'(expand5(w0[15:11]));
        e0[1] = 32'(expand6(w0[10:5]));
        e0[2] = 32'(expand5(w0[4:0]));
        e1[0] = 32'(expand5(w1[15:11]));
        e1[1] = 32'(expand6(w1[10:5]));
        e1[2] = 32'(expand5(w1[4:0]));
        for (int c = 0; c < 3; c++) begin
            case (sel)
                2'd0: v[c] = e0[c];
                2'd1: v[c] = e1[c];
                2'd2: v[c] = four ? (2 * e0[c] + e1[c]) / 3 : (e0[c] + e1[c]) / 2;
                default: v[c] = four ? (e0[c] + 2 * e1[c]) / 3 : 0;
            endcase
        end
        px.r = 8'(v[0]);
        px.g = 8'(v[1]);
        px.b = 8'(v[2]);
        // three-colour mode, selector 3: transparent black
        px.a = (sel == 2'd3 && !four) ? 8'd0 : 8'd255;
        return px;
    endfunction

    // e0 in bits 7:0, e1 in 15:8, 3-bit selectors from bit 16
    function automatic logic [7:0] channel_texel(input logic [63:0] bits, input int p);
        int unsigned e0;
        int unsigned e1;
        int unsigned k;
        e0 = 32'(bits[7:0]);
        e1 = 32'(bits[15:8]);
        k = 32'(bits[16 + 3*p +: 3]);
        if (k == 0) return 8'(e0);
        if (k == 1) return 8'(e1);
        if (e0 > e1) return 8'(((8 - k) * e0 + (k - 1) * e1) / 7);
        if (k == 6) return 8'd0;
        if (k == 7) return 8'd255;
        return 8'(((6 - k) * e0 + (k - 1) * e1) / 5);
    endfunction

    always @(posedge i_clk) begin
        t_texel want;
        t_texel got;
        t_rgba  px;
        if (!i_rst_n) begin
            cur_format = FMT_BC1;
            texel_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == 3'd0)
                        cur_format = i_pwdata[2:0];
                end else if (i_paddr == 3'd0 && i_prdata !== {29'd0, cur_format}) begin
                    fails++;
                    if (fails <= 10)
                        $display("format readback: expected %0d, got %h", cur_format,
                                 i_prdata);
                end
            end

            if (i_out_valid && !i_out_stall) begin
                got = '{i_texel_pos, i_red, i_green, i_blue, i_alpha, i_last_pixel};
                if (texel_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("pixel with nothing pending: idx %0d rgba %h %h %h %h last %b",
                                 got.index, got.red, got.green, got.blue, got.alpha, got.last);
                end else begin
                    want = texel_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("pixel mismatch: expected idx %0d rgba %h %h %h %h last %b",
                                     want.index, want.red, want.green, want.blue, want.alpha,
                                     want.last);
                            $display("                got      idx %0d rgba %h %h %h %h last %b",
                                     got.index, got.red, got.green, got.blue, got.alpha,
                                     got.last);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                for (int p = 0; p < PIXELS; p++) begin
                    case (cur_format)
                        FMT_BC1: px = colour_texel(i_block_low, p, 1'b0);
                        FMT_BC2: begin
                            px = colour_texel(i_block_high, p, 1'b1);
                            px.a = 8'(i_block_low[4*p +: 4] * 17);
                        end
                        FMT_BC3: begin
                            px = colour_texel(i_block_high, p, 1'b1);
                            px.a = channel_texel(i_block_low, p);
                        end
                        FMT_BC4: begin
                            px.r = channel_texel(i_block_low, p);
                            px.g = px.r;
                            px.b = px.r;
                            px.a = 8'd255;
                        end
                        FMT_BC5: begin
                            px.r = channel_texel(i_block_low, p);
                            px.g = channel_texel(i_block_high, p);
                            px.b = 8'd0;
                            px.a = 8'd255;
                        end
                        default: px = '0;
                    endcase
                    want = '{4'(p), px.r, px.g, px.b, px.a, (p == PIXELS - 1)};
                    texel_q.push_back(want);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= texel_q.size();
    end

endmodule

// ----- dv/bcn_block_decoder_tb.sv -----
module bcn_block_decoder_tb
    import bcn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 19;
    localparam int PHASE_LEN  = 19;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] block_low = '0;
    logic [63:0] block_high = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  texel_pos;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_pixel;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    bcn_block_decoder u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_block_low   (block_low),
        .i_block_high  (block_high),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_texel_pos   (texel_pos),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_alpha       (alpha),
        .o_last_pixel  (last_pixel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bcn_block_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_block_low   (block_low),
        .i_block_high  (block_high),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_texel_pos   (texel_pos),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_alpha       (alpha),
        .i_last_pixel  (last_pixel),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // selectors 0..7 repeating over the sixteen pixels
    function automatic logic [47:0] sel_ramp();
        logic [47:0] r;
        for (int p = 0; p < 16; p++)
            r[3*p +: 3] = 3'(p);
        return r;
    endfunction

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid   <= 1'b1;
        block_low  <= lo;
        block_high <= hi;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // only between blocks: drain, let the pipe settle, write, read back
    task automatic set_format(input logic [2:0] addr, input logic [2:0] fmt);
        wait_drained();
        repeat (4) @(posedge clk);
        apb_access(1'b1, addr, ($urandom & 32'hFFFF_FFF8) | 32'(fmt));
        apb_access(1'b0, 3'd0, 32'd0);
    endtask

    initial begin
        logic [2:0]  phase_fmt[PHASES];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [47:0] ramp;
        phase_fmt = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC4, FMT_BC5, 3'd5, FMT_BC1, FMT_BC5,
                      FMT_BC3, 3'd7, FMT_BC2, FMT_BC4, 3'd6, FMT_BC5, FMT_BC1, FMT_BC3,
                      FMT_BC2, FMT_BC4, FMT_BC1};
        ramp = sel_ramp();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset format is BC1: four-colour, three-colour, equal endpoints
        lo = {32'hE4E4E4E4, 16'h0000, 16'hFFFF};
        send_block(lo, ~lo);
        lo = {32'hE4E4E4E4, 16'hFFFF, 16'h0000};
        send_block(lo, ~lo);
        lo = {32'h1B1B1B1B, 16'h8410, 16'h8410};
        send_block(lo, ~lo);
        lo = {32'hE4E4E4E4, 16'hF81F, 16'h07E0};
        send_block(lo, ~lo);
        send_block('0, '1);
        send_block('1, '0);

        // explicit alpha, colour forced to four-colour mode
        set_format(3'd0, FMT_BC2);
        send_block(64'hFEDC_BA98_7654_3210, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        send_block('0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block('1, '1);

        set_format(3'd0, FMT_BC3);
        send_block({ramp, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block({ramp, 8'hF0, 8'h10}, {32'h1B1B1B1B, 16'h0000, 16'hFFFF});
        send_block({ramp, 8'h80, 8'h80}, '1);
        send_block('1, '0);
        send_block({ramp, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h8410, 16'h8410});

        set_format(3'd0, FMT_BC4);
        send_block({ramp, 8'h00, 8'hFF}, '1);
        send_block({ramp, 8'hFF, 8'h00}, '0);
        send_block('0, '1);

        set_format(3'd0, FMT_BC5);
        send_block({ramp, 8'h10, 8'hF0}, {ramp, 8'hF0, 8'h10});
        send_block('1, '1);

        // codes past BC5 decode to transparent black
        set_format(3'd0, 3'd5);
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        set_format(3'd0, 3'd7);
        send_block('1, '1);
        set_format(3'd0, 3'd6);
        // a write to the next word address must leave the format alone
        set_format(3'd4, FMT_BC1);
        send_block({ramp, 8'h00, 8'hFF}, {ramp, 8'hFF, 8'h00});

        for (int ph = 0; ph < PHASES; ph++) begin
            set_format(3'd0, phase_fmt[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                case ($urandom_range(11))
                    0: begin lo[15:8] = lo[7:0]; hi[15:8] = hi[7:0]; end
                    1: begin lo[31:16] = lo[15:0]; hi[31:16] = hi[15:0]; end
                    2: begin lo[15:0] = {8'h00, 8'hFF}; hi[15:0] = {8'hFF, 8'h00}; end
                    3: lo = '1;
                    4: hi = '0;
                    default: ;
                endcase
                send_block(lo, hi);
                if (ph == 6 && n == 10)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
